// ===== rtl/core/stnvs_pkg.sv =====
// Shared types and constants for the sorted table nearest value search block.
package stnvs_pkg;
	localparam int TableDepth = 256;
	localparam int KeyWidth   = 32;
	localparam int IdWidth    = 16;
	localparam int AddrWidth  = $clog2(TableDepth);
	localparam int CountWidth = AddrWidth + 1;

	typedef logic [KeyWidth-1:0]   key_t;
	typedef logic [IdWidth-1:0]    id_t;
	typedef logic [AddrWidth-1:0]  addr_t;
	typedef logic [CountWidth-1:0] count_t;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_REMOVE = 3'd2,
		OP_SORT   = 3'd3,
		OP_QUERY  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_BAD_IDX = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_NO_NBR  = 3'd4
	} status_t;

	// Absolute difference of two keys
	function automatic key_t key_dist(input key_t a, input key_t b);
		key_dist = (a >= b) ? key_t'(a - b) : key_t'(b - a);
	endfunction
endpackage

// ===== rtl/core/stnvs_table_ram.sv =====
// Entry store: key and tag memory, one write port and one registered read port.
module stnvs_table_ram (
	input  logic            clk,
	input  logic            we,
	input  stnvs_pkg::addr_t waddr,
	input  stnvs_pkg::key_t  wkey,
	input  stnvs_pkg::id_t   wid,
	input  stnvs_pkg::addr_t raddr,
	output stnvs_pkg::key_t  rkey,
	output stnvs_pkg::id_t   rid
);
	import stnvs_pkg::*;

	key_t key_mem [TableDepth];
	id_t  id_mem  [TableDepth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			id_mem[waddr]  <= wid;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rkey <= key_mem[raddr];
		rid  <= id_mem[raddr];
	end
endmodule

// ===== rtl/core/stnvs_range_stack.sv =====
// Sort work list: stack of (lo, hi) range pairs held in memory.
module stnvs_range_stack (
	input  logic             clk,
	input  logic             we,
	input  stnvs_pkg::addr_t waddr,
	input  stnvs_pkg::addr_t wlo,
	input  stnvs_pkg::addr_t whi,
	input  stnvs_pkg::addr_t raddr,
	output stnvs_pkg::addr_t rlo,
	output stnvs_pkg::addr_t rhi
);
	import stnvs_pkg::*;

	logic [2*AddrWidth-1:0] mem [TableDepth/2];
	logic [2*AddrWidth-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[AddrWidth-1:1]] <= {wlo, whi};
		end
		rd_q <= mem[raddr[AddrWidth-1:1]];
	end

	assign rlo = rd_q[2*AddrWidth-1:AddrWidth];
	assign rhi = rd_q[AddrWidth-1:0];
endmodule

// ===== rtl/core/sorted_table_nearest_value_search.sv =====
// Sorted table nearest value search: top level with the operation sequencer.
// One transaction at a time. Remove moves the entries above the index down one place; sort
// runs Lomuto partitioning over the one entry memory port; a query checks the end points,
// runs a binary search, then picks around the landing place. All of them share the single
// read port of the entry memory.
// The result waits in an output register; reading an entry never written is undefined.
module sorted_table_nearest_value_search (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          operation,
	input  stnvs_pkg::key_t     entry_key,
	input  stnvs_pkg::id_t      entry_id,
	input  logic [7:0]          remove_index,
	input  logic                prev_valid,
	input  stnvs_pkg::key_t     prev_key,
	input  stnvs_pkg::id_t      prev_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output stnvs_pkg::id_t      result_id,
	output stnvs_pkg::key_t     result_key,
	output stnvs_pkg::count_t   entry_count
);
	import stnvs_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_DISPATCH, S_DONE,
		// remove
		S_RM_RD, S_RM_WAIT, S_RM_WR,
		// sort
		S_SO_POP, S_SO_POPW, S_SO_POPD, S_SO_PIV, S_SO_PIVW,
		S_SO_SCAN, S_SO_SCANW, S_SO_SCANC, S_SO_SWPW, S_SO_SWPA,
		S_SO_FIN, S_SO_FINW, S_SO_FINA, S_SO_FINB, S_SO_SPLIT,
		// query
		S_Q_FIRST, S_Q_FIRSTW, S_Q_LAST, S_Q_LASTW, S_Q_CHK,
		S_Q_MID, S_Q_MIDW, S_Q_NB, S_Q_NBW, S_Q_DEC,
		S_Q_PK, S_Q_PKW, S_Q_PKLO, S_Q_PKLOW, S_Q_PKHI, S_Q_PKHIW, S_Q_PKD,
		S_Q_SEL, S_Q_SELW, S_Q_FIN
	} state_t;

	state_t  state_q;
	op_t     op_q;
	key_t    key_q, pkey_q, k0_q, kn_q, ka_q, kb_q, pivot_q;
	id_t     id_q, pid_q, ida_q, idb_q;
	logic    pv_q;
	count_t  fill_q;
	logic [AddrWidth:0] lo_q, hi_q, i_q, p_q, m_q, sp_q, mid_q;
	logic    nb_lo_q;
	status_t st_q;
	key_t    rkey_q;
	id_t     rid_q;
	logic    ov_q;

	// Entry memory port
	logic   we;
	addr_t  waddr, raddr;
	key_t   wkey, rkey;
	id_t    wid, rid;

	// Range stack port
	logic   s_we;
	addr_t  s_waddr, s_wlo, s_whi, s_raddr, s_rlo, s_rhi;

	stnvs_table_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wkey(wkey), .wid(wid),
		.raddr(raddr), .rkey(rkey), .rid(rid)
	);

	stnvs_range_stack u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wlo(s_wlo), .whi(s_whi),
		.raddr(s_raddr), .rlo(s_rlo), .rhi(s_rhi)
	);

	// Split of a partitioned range, worked from p_q
	logic lnon, rnon, lsmall;
	assign lnon   = p_q > lo_q + 1'b1;
	assign rnon   = p_q + 1'b1 < hi_q;
	assign lsmall = (p_q - 1'b1 - lo_q) < (hi_q - p_q - 1'b1);

	// Memory control
	always_comb begin
		we    = 1'b0;
		waddr = addr_t'(i_q);
		wkey  = ka_q;
		wid   = ida_q;
		raddr = addr_t'(i_q);
		s_we    = 1'b0;
		s_waddr = addr_t'(sp_q);
		s_wlo   = addr_t'(p_q + 1'b1);
		s_whi   = addr_t'(hi_q);
		s_raddr = addr_t'(sp_q - 2'd2);
		case (state_q)
			S_DISPATCH: begin
				we    = (op_q == OP_APPEND) && (fill_q < count_t'(TableDepth));
				waddr = addr_t'(fill_q);
				wkey  = key_q;
				wid   = id_q;
			end
			S_RM_RD, S_RM_WAIT: raddr = addr_t'(i_q + 1'b1);
			S_RM_WR: begin
				we = 1'b1; wkey = rkey; wid = rid;
			end
			S_SO_PIV: raddr = addr_t'(hi_q);
			S_SO_SCAN: raddr = addr_t'(i_q);
			S_SO_SCANC: raddr = addr_t'(p_q);
			S_SO_SWPA: begin
				// write old entry i at p, entry p at i follows
				we = 1'b1; waddr = addr_t'(p_q); wkey = ka_q; wid = ida_q;
			end
			// second half of a scan swap: old entry p written at i
			S_SO_FINW: we = nb_lo_q;
			S_SO_FIN: raddr = addr_t'(p_q);
			S_SO_FINA: begin
				we = 1'b1; waddr = addr_t'(p_q); wkey = ka_q; wid = ida_q;
			end
			S_SO_FINB: begin
				we = 1'b1; waddr = addr_t'(hi_q); wkey = kb_q; wid = idb_q;
			end
			S_SO_SPLIT: begin
				if (lnon && rnon) begin
					s_we = 1'b1;
					if (!lsmall) begin
						s_wlo = addr_t'(lo_q);
						s_whi = addr_t'(p_q - 1'b1);
					end
				end
			end
			S_Q_FIRST: raddr = '0;
			S_Q_LAST:  raddr = addr_t'(fill_q - 1'b1);
			S_Q_MID:   raddr = addr_t'(mid_q);
			S_Q_NB:    raddr = nb_lo_q ? addr_t'(mid_q - 1'b1) : addr_t'(mid_q + 1'b1);
			S_Q_PK:    raddr = addr_t'(m_q);
			S_Q_PKLO:  raddr = addr_t'(m_q - 1'b1);
			S_Q_PKHI:  raddr = addr_t'(m_q + 1'b1);
			S_Q_SEL:   raddr = addr_t'(m_q);
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE) && !ov_q;

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			ov_q    <= 1'b0;
			op_q    <= OP_CLEAR;
			sp_q    <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q   <= op_t'(operation);
						key_q  <= entry_key;
						id_q   <= entry_id;
						pv_q   <= prev_valid;
						pkey_q <= prev_key;
						pid_q  <= prev_id;
						i_q    <= {1'b0, remove_index};
						st_q   <= ST_OK;
						rkey_q <= '0;
						rid_q  <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (op_q)
						OP_CLEAR: begin
							fill_q <= '0; state_q <= S_DONE;
						end
						OP_APPEND: begin
							if (fill_q >= count_t'(TableDepth)) st_q <= ST_FULL;
							else fill_q <= fill_q + 1'b1;
							state_q <= S_DONE;
						end
						OP_REMOVE: begin
							if (i_q >= fill_q) begin
								st_q <= ST_BAD_IDX; state_q <= S_DONE;
							end else begin
								state_q <= S_RM_RD;
							end
						end
						OP_SORT: begin
							if (fill_q < 2) state_q <= S_DONE;
							else begin
								lo_q <= '0; hi_q <= fill_q - 1'b1;
								sp_q <= '0; state_q <= S_SO_PIV;
							end
						end
						OP_QUERY: begin
							if (fill_q == 0) begin
								st_q <= ST_EMPTY; state_q <= S_DONE;
							end else state_q <= S_Q_FIRST;
						end
						default: state_q <= S_DONE;
					endcase
				end
				// remove: move entries down one place
				S_RM_RD: begin
					if (i_q + 1'b1 >= fill_q) begin
						fill_q <= fill_q - 1'b1; state_q <= S_DONE;
					end else state_q <= S_RM_WAIT;
				end
				S_RM_WAIT: state_q <= S_RM_WR;
				S_RM_WR: begin
					i_q <= i_q + 1'b1; state_q <= S_RM_RD;
				end
				// sort: pop a range
				S_SO_POP: begin
					if (sp_q < 2) state_q <= S_DONE;
					else state_q <= S_SO_POPW;
				end
				S_SO_POPW: state_q <= S_SO_POPD;
				S_SO_POPD: begin
					lo_q <= {1'b0, s_rlo}; hi_q <= {1'b0, s_rhi};
					sp_q <= sp_q - 2'd2;
					state_q <= (s_rlo < s_rhi) ? S_SO_PIV : S_SO_POP;
				end
				S_SO_PIV: state_q <= S_SO_PIVW;
				S_SO_PIVW: begin
					i_q <= lo_q; p_q <= lo_q; state_q <= S_SO_SCAN;
				end
				S_SO_SCAN: begin
					if (i_q >= hi_q) state_q <= S_SO_FIN;
					else state_q <= S_SO_SCANW;
				end
				S_SO_SCANW: state_q <= S_SO_SCANC;
				S_SO_SCANC: begin
					// pivot captured on first pass via PIV read
					if (rkey < pivot_q) begin
						ka_q <= rkey; ida_q <= rid; state_q <= S_SO_SWPW;
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_SO_SCAN;
					end
				end
				S_SO_SWPW: begin
					// rkey/rid now entry p; write it to i
					kb_q <= rkey; idb_q <= rid; state_q <= S_SO_SWPA;
				end
				S_SO_SWPA: begin
					ka_q <= kb_q; ida_q <= idb_q; state_q <= S_SO_FINW;
					nb_lo_q <= 1'b1;
				end
				S_SO_FIN: begin
					nb_lo_q <= 1'b0; state_q <= S_SO_FINW;
				end
				S_SO_FINW: begin
					if (nb_lo_q) begin
						// second half of a scan swap: entry p goes to i
						nb_lo_q <= 1'b0;
						p_q <= p_q + 1'b1;
						i_q <= i_q + 1'b1;
						state_q <= S_SO_SCAN;
					end else begin
						ka_q <= pivot_q; ida_q <= pid_q;
						kb_q <= rkey; idb_q <= rid;
						state_q <= S_SO_FINA;
					end
				end
				S_SO_FINA: state_q <= S_SO_FINB;
				S_SO_FINB: state_q <= S_SO_SPLIT;
				S_SO_SPLIT: begin
					if (!lnon && !rnon) state_q <= S_SO_POP;
					else begin
						if (!lnon) lo_q <= p_q + 1'b1;
						else if (!rnon) hi_q <= p_q - 1'b1;
						else begin
							sp_q <= sp_q + 2'd2;
							if (lsmall) hi_q <= p_q - 1'b1;
							else lo_q <= p_q + 1'b1;
						end
						state_q <= S_SO_PIV;
					end
				end
				// query: end points
				S_Q_FIRST: state_q <= S_Q_FIRSTW;
				S_Q_FIRSTW: begin
					k0_q <= rkey; state_q <= S_Q_LAST;
				end
				S_Q_LAST: state_q <= S_Q_LASTW;
				S_Q_LASTW: begin
					kn_q <= rkey; state_q <= S_Q_CHK;
				end
				S_Q_CHK: begin
					lo_q <= '0; hi_q <= fill_q;
					if (key_q <= k0_q) begin
						m_q <= '0; state_q <= S_Q_PK;
					end else if (key_q >= kn_q) begin
						m_q <= fill_q - 1'b1; state_q <= S_Q_PK;
					end else begin
						mid_q <= fill_q >> 1; state_q <= S_Q_MID;
					end
				end
				// query: binary search step
				S_Q_MID: state_q <= S_Q_MIDW;
				S_Q_MIDW: begin
					ka_q <= rkey;
					if (key_q == rkey) begin
						m_q <= mid_q; state_q <= S_Q_PK;
					end else if (key_q < rkey) begin
						if (mid_q > 0) begin
							nb_lo_q <= 1'b1; state_q <= S_Q_NB;
						end else begin
							hi_q <= mid_q; state_q <= S_Q_DEC;
						end
					end else begin
						if (mid_q + 1'b1 < fill_q) begin
							nb_lo_q <= 1'b0; state_q <= S_Q_NB;
						end else begin
							lo_q <= mid_q + 1'b1; state_q <= S_Q_DEC;
						end
					end
				end
				S_Q_NB: state_q <= S_Q_NBW;
				S_Q_NBW: begin
					if (nb_lo_q) begin
						if (key_q > rkey) begin
							m_q <= (key_dist(key_q, rkey) >= key_dist(key_q, ka_q))
								? mid_q : mid_q - 1'b1;
							state_q <= S_Q_PK;
						end else begin
							hi_q <= mid_q; state_q <= S_Q_DEC;
						end
					end else begin
						if (key_q < rkey) begin
							m_q <= (key_dist(key_q, ka_q) >= key_dist(key_q, rkey))
								? mid_q + 1'b1 : mid_q;
							state_q <= S_Q_PK;
						end else begin
							lo_q <= mid_q + 1'b1; state_q <= S_Q_DEC;
						end
					end
				end
				S_Q_DEC: begin
					if (lo_q < hi_q) begin
						mid_q <= (lo_q + hi_q) >> 1; state_q <= S_Q_MID;
					end else begin
						if (pv_q) begin
							rkey_q <= pkey_q; rid_q <= pid_q;
						end else st_q <= ST_NO_NBR;
						state_q <= S_DONE;
					end
				end
				// query: pick around the landing place
				S_Q_PK: state_q <= S_Q_PKW;
				S_Q_PKW: begin
					if (rid != id_q) state_q <= S_Q_SEL;
					else if (m_q == 0 && m_q + 1'b1 >= fill_q) state_q <= S_Q_FIN;
					else if (m_q == 0) begin
						m_q <= m_q + 1'b1; state_q <= S_Q_SEL;
					end else if (m_q + 1'b1 >= fill_q) begin
						m_q <= m_q - 1'b1; state_q <= S_Q_SEL;
					end else if (key_q <= k0_q) begin
						m_q <= m_q + 1'b1; state_q <= S_Q_SEL;
					end else if (key_q >= kn_q) begin
						m_q <= m_q - 1'b1; state_q <= S_Q_SEL;
					end else state_q <= S_Q_PKLO;
				end
				S_Q_PKLO: state_q <= S_Q_PKLOW;
				S_Q_PKLOW: begin
					ka_q <= rkey; state_q <= S_Q_PKHI;
				end
				S_Q_PKHI: state_q <= S_Q_PKHIW;
				S_Q_PKHIW: begin
					kb_q <= rkey; state_q <= S_Q_PKD;
				end
				S_Q_PKD: begin
					m_q <= (key_dist(key_q, ka_q) >= key_dist(kb_q, key_q))
						? m_q + 1'b1 : m_q - 1'b1;
					state_q <= S_Q_SEL;
				end
				S_Q_SEL: state_q <= S_Q_SELW;
				S_Q_SELW: begin
					if (pv_q && key_dist(key_q, pkey_q) < key_dist(key_q, rkey)) begin
						rkey_q <= pkey_q; rid_q <= pid_q;
					end else begin
						rkey_q <= rkey; rid_q <= rid;
					end
					state_q <= S_DONE;
				end
				S_Q_FIN: begin
					// target alone in the table
					if (pv_q) begin
						rkey_q <= pkey_q; rid_q <= pid_q;
					end else st_q <= ST_NO_NBR;
					state_q <= S_DONE;
				end
				S_DONE: begin
					ov_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// pivot read issued in S_SO_PIV lands in S_SO_PIVW
			if (state_q == S_SO_PIVW) begin
				pivot_q <= rkey; pid_q <= rid;
			end
		end
	end

	assign out_valid   = ov_q;
	assign status      = st_q;
	assign result_id   = rid_q;
	assign result_key  = rkey_q;
	assign entry_count = fill_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= count_t'(TableDepth))
		else $error("fill count beyond table depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("ready while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> out_valid)
		else $error("finished transaction not presented");
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the sorted table nearest value search block: directed table then random traffic.
`timescale 1ns / 1ps

module tb_top;
	import stnvs_pkg::*;

	localparam int WatchdogCycles = 800000;
	localparam int RandomItems    = 1570;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	logic [2:0] operation;
	key_t     entry_key;
	id_t      entry_id;
	logic [7:0] remove_index;
	logic     prev_valid;
	key_t     prev_key;
	id_t      prev_id;
	logic     out_valid;
	logic     out_ready;
	logic [2:0] status;
	id_t      result_id;
	key_t     result_key;
	count_t   entry_count;

	typedef struct packed {
		logic [2:0] op;
		key_t       key;
		id_t        id;
		logic [7:0] idx;
		logic       pv;
		key_t       pkey;
		id_t        pid;
	} txn_t;

	typedef struct packed {
		logic [2:0] st;
		id_t        rid;
		key_t       rkey;
		count_t     cnt;
	} answer_t;

	// Row of the directed table: stimulus plus an optional typed-in answer
	typedef struct {
		txn_t    t;
		bit      fixed;
		answer_t a;
	} row_t;

	// Shadow table
	key_t   shadow_key [TableDepth];
	id_t    shadow_id  [TableDepth];
	int     shadow_fill;
	int     range_list [TableDepth];

	answer_t pending_answers [$];
	txn_t    send_queue [$];
	int      fail_count;
	int      idle_cycles;
	bit      sending_done;

	sorted_table_nearest_value_search i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .entry_key(entry_key), .entry_id(entry_id),
		.remove_index(remove_index), .prev_valid(prev_valid),
		.prev_key(prev_key), .prev_id(prev_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_id(result_id), .result_key(result_key),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic key_t gap(key_t a, key_t b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic void swap_slots(int a, int b);
		key_t k;
		id_t  d;
		k = shadow_key[a]; d = shadow_id[a];
		shadow_key[a] = shadow_key[b]; shadow_id[a] = shadow_id[b];
		shadow_key[b] = k; shadow_id[b] = d;
	endfunction

	function automatic int split_range(int lo, int hi);
		key_t pivot;
		int   p;
		pivot = shadow_key[hi];
		p = lo;
		for (int i = lo; i < hi; i++)
			if (shadow_key[i] < pivot) begin
				swap_slots(i, p);
				p++;
			end
		swap_slots(hi, p);
		return p;
	endfunction

	// Lomuto quicksort, smaller part first, larger part parked on the range list
	function automatic void sort_shadow();
		int sp, lo, hi, p, lhi;
		bit lnon, rnon;
		sp = 0;
		if (shadow_fill < 2) return;
		range_list[sp++] = 0;
		range_list[sp++] = shadow_fill - 1;
		while (sp >= 2) begin
			hi = range_list[--sp];
			lo = range_list[--sp];
			while (lo < hi) begin
				p = split_range(lo, hi);
				lhi = (p > lo) ? p - 1 : lo;
				lnon = p > lo + 1;
				rnon = p + 1 < hi;
				if (!lnon && !rnon) break;
				if (!lnon) begin
					lo = p + 1;
					continue;
				end
				if (!rnon) begin
					hi = lhi;
					continue;
				end
				if (lhi - lo < hi - (p + 1)) begin
					if (sp + 2 <= TableDepth) begin
						range_list[sp++] = p + 1; range_list[sp++] = hi;
					end
					hi = lhi;
				end else begin
					if (sp + 2 <= TableDepth) begin
						range_list[sp++] = lo; range_list[sp++] = lhi;
					end
					lo = p + 1;
				end
			end
		end
	endfunction

	// Choose a slot, stepping off the target's own tag to its closer neighbour
	function automatic bit choose_slot(int m, key_t t, id_t tid, output int sel);
		int  n;
		bit  has_lo, has_hi;
		n = shadow_fill;
		sel = m;
		if (shadow_id[m] != tid) return 1;
		has_lo = m > 0;
		has_hi = m + 1 < n;
		if (!has_lo && !has_hi) return 0;
		if (!has_lo) sel = m + 1;
		else if (!has_hi) sel = m - 1;
		else if (t <= shadow_key[0]) sel = m + 1;
		else if (t >= shadow_key[n-1]) sel = m - 1;
		else if (gap(t, shadow_key[m-1]) >= gap(shadow_key[m+1], t)) sel = m + 1;
		else sel = m - 1;
		return 1;
	endfunction

	function automatic bit find_nearest(key_t t, id_t tid, output int sel);
		int n, lo, hi, mid;
		n = shadow_fill; lo = 0; hi = n; sel = 0;
		if (t <= shadow_key[0]) return choose_slot(0, t, tid, sel);
		if (t >= shadow_key[n-1]) return choose_slot(n - 1, t, tid, sel);
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (t == shadow_key[mid]) return choose_slot(mid, t, tid, sel);
			if (t < shadow_key[mid]) begin
				if (mid > 0 && t > shadow_key[mid-1]) begin
					if (gap(t, shadow_key[mid-1]) >= gap(t, shadow_key[mid]))
						return choose_slot(mid, t, tid, sel);
					return choose_slot(mid - 1, t, tid, sel);
				end
				hi = mid;
			end else begin
				if (mid + 1 < n && t < shadow_key[mid+1]) begin
					if (gap(t, shadow_key[mid]) >= gap(t, shadow_key[mid+1]))
						return choose_slot(mid + 1, t, tid, sel);
					return choose_slot(mid, t, tid, sel);
				end
				lo = mid + 1;
			end
		end
		return 0;
	endfunction

	// Apply one transaction to the shadow table and return its answer
	function automatic answer_t apply_txn(txn_t t);
		answer_t a;
		int      sel;
		a = '0;
		a.st = ST_OK;
		case (t.op)
			OP_CLEAR: shadow_fill = 0;
			OP_APPEND: begin
				if (shadow_fill >= TableDepth) a.st = ST_FULL;
				else begin
					shadow_key[shadow_fill] = t.key;
					shadow_id[shadow_fill] = t.id;
					shadow_fill++;
				end
			end
			OP_REMOVE: begin
				if (int'(t.idx) >= shadow_fill) a.st = ST_BAD_IDX;
				else begin
					for (int i = t.idx; i + 1 < shadow_fill; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_id[i] = shadow_id[i+1];
					end
					shadow_fill--;
				end
			end
			OP_SORT: sort_shadow();
			OP_QUERY: begin
				if (shadow_fill == 0) a.st = ST_EMPTY;
				else if (find_nearest(t.key, t.id, sel)) begin
					a.rkey = shadow_key[sel];
					a.rid = shadow_id[sel];
					if (t.pv && gap(t.key, t.pkey) < gap(t.key, a.rkey)) begin
						a.rkey = t.pkey;
						a.rid = t.pid;
					end
				end else if (t.pv) begin
					a.rkey = t.pkey;
					a.rid = t.pid;
				end else a.st = ST_NO_NBR;
			end
			default: ;
		endcase
		a.cnt = count_t'(shadow_fill);
		return a;
	endfunction

	function automatic txn_t mk(logic [2:0] op, key_t k, id_t d, logic [7:0] ix,
			logic pv, key_t pk, id_t pd);
		txn_t t;
		t.op = op; t.key = k; t.id = d; t.idx = ix; t.pv = pv; t.pkey = pk; t.pid = pd;
		return t;
	endfunction

	function automatic txn_t rand_txn(int base_key);
		txn_t t;
		int   r;
		r = $urandom_range(99);
		t = mk(OP_QUERY, key_t'($urandom), id_t'($urandom), 8'($urandom), 1'($urandom),
			key_t'($urandom), id_t'($urandom));
		// Keys clustered so queries hit duplicates and exact targets
		if ($urandom_range(1)) t.key = key_t'(base_key + $urandom_range(63));
		if (r < 45) t.op = OP_APPEND;
		else if (r < 60) t.op = OP_SORT;
		else if (r < 70) t.op = OP_REMOVE;
		else if (r < 72) t.op = OP_CLEAR;
		else if (r < 74) t.op = 3'($urandom_range(7, 5));
		if (t.op == OP_REMOVE && $urandom_range(3) != 0 && shadow_fill > 0)
			t.idx = 8'($urandom_range(shadow_fill - 1));
		// Query on a tag that is in the table
		if (t.op == OP_QUERY && shadow_fill > 0 && $urandom_range(1)) begin
			r = $urandom_range(shadow_fill - 1);
			t.id = shadow_id[r];
			if ($urandom_range(1)) t.key = shadow_key[r];
		end
		return t;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(3);
		return $urandom_range(40);
	endfunction

	row_t    directed [$];

	function automatic void add_row(txn_t t, bit fixed, answer_t a);
		row_t r;
		r.t = t; r.fixed = fixed; r.a = a;
		directed.insert(directed.size(), r);
	endfunction

	function automatic answer_t ans(logic [2:0] st, id_t d, key_t k, count_t c);
		answer_t a;
		a.st = st; a.rid = d; a.rkey = k; a.cnt = c;
		return a;
	endfunction

	// Stimulus driver
	initial begin
		txn_t t;
		int   wait_n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{operation, entry_key, entry_id, remove_index, prev_valid, prev_key, prev_id} = '0;
		shadow_fill = 0;
		fail_count = 0;
		sending_done = 0;

		// Directed table
		add_row(mk(OP_QUERY, 5, 1, 0, 0, 0, 0), 1, ans(ST_EMPTY, 0, 0, 0));
		add_row(mk(OP_QUERY, 5, 1, 0, 1, 9, 7), 1, ans(ST_EMPTY, 0, 0, 0));
		add_row(mk(OP_REMOVE, 0, 0, 0, 0, 0, 0), 1, ans(ST_BAD_IDX, 0, 0, 0));
		add_row(mk(OP_APPEND, '1, '1, '1, 1, '1, '1), 1, ans(ST_OK, 0, 0, 1));
		add_row(mk(OP_QUERY, '1, '1, 0, 0, 0, 0), 1, ans(ST_NO_NBR, 0, 0, 1));
		add_row(mk(OP_QUERY, '1, '1, 0, 1, 3, 16'h1234), 1, ans(ST_OK, 16'h1234, 3, 1));
		add_row(mk(3'd5, 1, 1, 1, 1, 1, 1), 1, ans(ST_OK, 0, 0, 1));
		add_row(mk(3'd7, 1, 1, 1, 1, 1, 1), 1, ans(ST_OK, 0, 0, 1));
		add_row(mk(OP_APPEND, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 2));
		add_row(mk(OP_APPEND, 100, 2, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 3));
		add_row(mk(OP_APPEND, 100, 3, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 4));
		add_row(mk(OP_APPEND, 40, 4, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 5));
		add_row(mk(OP_SORT, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 5));
		add_row(mk(OP_QUERY, 100, 2, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_QUERY, 0, 0, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_QUERY, '1, '1, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_QUERY, 70, 9, 0, 1, 69, 8), 0, '0);
		add_row(mk(OP_QUERY, 60, 9, 0, 1, 90, 8), 0, '0);
		add_row(mk(OP_REMOVE, 0, 0, 4, 0, 0, 0), 1, ans(ST_OK, 0, 0, 4));
		add_row(mk(OP_REMOVE, 0, 0, 8'd255, 0, 0, 0), 1, ans(ST_BAD_IDX, 0, 0, 4));
		add_row(mk(OP_QUERY, 1, 4, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0));
		// Fill to full, then overflow, sort a descending table, query, remove the last entry, and clear
		for (int i = 0; i < TableDepth; i++)
			add_row(mk(OP_APPEND, key_t'((TableDepth - i) * 1000), id_t'(i), 0, 0, 0, 0),
				1, ans(ST_OK, 0, 0, count_t'(i + 1)));
		add_row(mk(OP_APPEND, 1, 1, 0, 0, 0, 0), 1,
			ans(ST_FULL, 0, 0, count_t'(TableDepth)));
		add_row(mk(OP_SORT, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, count_t'(TableDepth)));
		add_row(mk(OP_QUERY, 500, 9999, 0, 0, 0, 0), 0, '0);
		add_row(mk(OP_REMOVE, 0, 0, 8'd255, 0, 0, 0), 1,
			ans(ST_OK, 0, 0, count_t'(TableDepth - 1)));
		add_row(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			pending_answers.insert(pending_answers.size(), directed[i].fixed ? directed[i].a
				: apply_txn(directed[i].t));
			if (directed[i].fixed) void'(apply_txn(directed[i].t));
			send_queue.insert(send_queue.size(), directed[i].t);
		end
		for (int i = 0; i < RandomItems; i++) begin
			// Appends dominate, then queries and sorts, with occasional removes, clears and illegal codes
			t = rand_txn(int'($urandom_range(3)) * 32'h4000_0000);
			pending_answers.insert(pending_answers.size(), apply_txn(t));
			send_queue.insert(send_queue.size(), t);
		end

		@(posedge clk);
		while (send_queue.size() > 0) begin
			wait_n = pause_len();
			if (wait_n > 0) begin
				in_valid <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			t = send_queue.pop_front();
			in_valid <= 1'b1;
			operation <= t.op; entry_key <= t.key; entry_id <= t.id;
			remove_index <= t.idx; prev_valid <= t.pv; prev_key <= t.pkey; prev_id <= t.pid;
			do @(posedge clk); while (!in_ready);
		end
		in_valid <= 1'b0;
		sending_done = 1;
	end

	// Result sink with random back-pressure
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			out_ready <= (pause_len() == 0) || ($urandom_range(3) == 0);
		end
	end

	// Compare each transaction against the oldest expected answer
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$error("result with nothing expected");
				fail_count++;
			end else begin
				e = pending_answers.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); fail_count++;
				end
				if (result_id !== e.rid) begin
					$error("result_id exp %0h got %0h", e.rid, result_id); fail_count++;
				end
				if (result_key !== e.rkey) begin
					$error("result_key exp %0h got %0h", e.rkey, result_key); fail_count++;
				end
				if (entry_count !== e.cnt) begin
					$error("entry_count exp %0d got %0d", e.cnt, entry_count); fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted transaction or taken result, then end of run
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		while (!(sending_done && pending_answers.size() == 0)
				&& idle_cycles < WatchdogCycles) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
			else idle_cycles++;
		end
		if (idle_cycles >= WatchdogCycles) begin
			$display("tb_top: FAIL");
		end else begin
			repeat (50) @(posedge clk);
			if (fail_count == 0 && !out_valid) $display("tb_top: PASS");
			else $display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
